// ===== src/decimal_text_to_number_parser_macros.svh =====
// Assertion helpers for the checker module.
`ifndef DECIMAL_TEXT_TO_NUMBER_PARSER_MACROS_SVH
`define DECIMAL_TEXT_TO_NUMBER_PARSER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define DTNP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtnp check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define DTNP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtnp check failed");

`endif

// ===== src/dtnp_pkg.sv =====
`timescale 1ns / 1ps
package dtnp_pkg;

  localparam int MANT_W    = 64;
  localparam int MANT_XW   = MANT_W + 4;
  localparam int FRAC_W    = 9;
  localparam int EXP_W     = 9;
  localparam int EXP_XW    = EXP_W + 4;
  localparam int DEC_EXP_W = 11;
  localparam int CH_W      = 8;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 80;

  localparam int DEF_MAX_EXPONENT = 308;

  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  localparam logic [2:0] PH_WS      = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_FRAC    = 3'd2;
  localparam logic [2:0] PH_EXPSIGN = 3'd3;
  localparam logic [2:0] PH_EXPDIG  = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_LO_E  = 8'h65;
  localparam logic [CH_W-1:0] CH_UP_E  = 8'h45;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [2:0]        phase;
    logic              neg;
    logic [MANT_W-1:0] mant;
    logic              mant_sat;
    logic [FRAC_W-1:0] frac_cnt;
    logic              exp_neg;
    logic [EXP_W-1:0]  exp_mag;
  } dtnp_state_t;

  localparam dtnp_state_t STATE_RST = '{
    phase:    PH_WS,
    neg:      1'b0,
    mant:     '0,
    mant_sat: 1'b0,
    frac_cnt: '0,
    exp_neg:  1'b0,
    exp_mag:  '0
  };

endpackage

// ===== src/dtnp_step.sv =====
`timescale 1ns / 1ps
module dtnp_step #(
  parameter int MAX_EXPONENT = dtnp_pkg::DEF_MAX_EXPONENT
) (
  input  dtnp_pkg::dtnp_state_t        cur,
  input  logic [dtnp_pkg::CH_W-1:0]    ch,
  output dtnp_pkg::dtnp_state_t        parsed
);

  localparam logic [dtnp_pkg::EXP_XW-1:0] EXP_LIMIT = dtnp_pkg::EXP_XW'(MAX_EXPONENT);
  localparam logic [dtnp_pkg::EXP_W-1:0]  EXP_CLAMP = dtnp_pkg::EXP_W'(MAX_EXPONENT);

  logic                            is_dig;
  logic                            is_e;
  logic [3:0]                      dval;
  logic [dtnp_pkg::MANT_XW-1:0]    mant_x;
  logic [dtnp_pkg::MANT_XW-1:0]    mant_sum;
  logic [dtnp_pkg::MANT_W-1:0]     mant_nxt;
  logic                            sat_nxt;
  logic [dtnp_pkg::EXP_XW-1:0]     exp_x;
  logic [dtnp_pkg::EXP_XW-1:0]     exp_sum;
  logic [dtnp_pkg::EXP_W-1:0]      exp_nxt;
  logic [dtnp_pkg::FRAC_W-1:0]     frac_nxt;

  assign is_dig = (ch >= dtnp_pkg::CH_ZERO) && (ch <= dtnp_pkg::CH_NINE);
  assign is_e   = (ch == dtnp_pkg::CH_LO_E) || (ch == dtnp_pkg::CH_UP_E);
  assign dval   = ch[3:0];

  // x10 + d as shift-add; any carry into the top nibble is an overflow
  assign mant_x   = {4'b0, cur.mant};
  assign mant_sum = (mant_x << 3) + (mant_x << 1) + {{(dtnp_pkg::MANT_XW-4){1'b0}}, dval};

  always_comb begin
    if (cur.mant_sat) begin
      mant_nxt = cur.mant;
      sat_nxt  = 1'b1;
    end else if (mant_sum[dtnp_pkg::MANT_XW-1:dtnp_pkg::MANT_W] != 4'b0) begin
      mant_nxt = {dtnp_pkg::MANT_W{1'b1}};
      sat_nxt  = 1'b1;
    end else begin
      mant_nxt = mant_sum[dtnp_pkg::MANT_W-1:0];
      sat_nxt  = 1'b0;
    end
  end

  assign exp_x   = {4'b0, cur.exp_mag};
  assign exp_sum = (exp_x << 3) + (exp_x << 1) + {{(dtnp_pkg::EXP_XW-4){1'b0}}, dval};
  assign exp_nxt = (exp_sum > EXP_LIMIT) ? EXP_CLAMP : exp_sum[dtnp_pkg::EXP_W-1:0];

  assign frac_nxt = (cur.frac_cnt < dtnp_pkg::FRAC_MAX) ?
                    cur.frac_cnt + dtnp_pkg::FRAC_W'(1) : cur.frac_cnt;

  always_comb begin
    parsed = cur;
    unique case (cur.phase)
      dtnp_pkg::PH_WS: begin
        if ((ch == dtnp_pkg::CH_SPACE) || (ch == dtnp_pkg::CH_TAB)) begin
          parsed.phase = dtnp_pkg::PH_WS;
        end else if (ch == dtnp_pkg::CH_MINUS) begin
          parsed.neg   = 1'b1;
          parsed.phase = dtnp_pkg::PH_INT;
        end else if (ch == dtnp_pkg::CH_PLUS) begin
          parsed.phase = dtnp_pkg::PH_INT;
        end else if (is_dig) begin
          parsed.mant     = mant_nxt;
          parsed.mant_sat = sat_nxt;
          parsed.phase    = dtnp_pkg::PH_INT;
        end else if (ch == dtnp_pkg::CH_DOT) begin
          parsed.phase = dtnp_pkg::PH_FRAC;
        end else if (is_e) begin
          parsed.phase = dtnp_pkg::PH_EXPSIGN;
        end else begin
          parsed.phase = dtnp_pkg::PH_DONE;
        end
      end
      dtnp_pkg::PH_INT: begin
        if (is_dig) begin
          parsed.mant     = mant_nxt;
          parsed.mant_sat = sat_nxt;
        end else if (ch == dtnp_pkg::CH_DOT) begin
          parsed.phase = dtnp_pkg::PH_FRAC;
        end else if (is_e) begin
          parsed.phase = dtnp_pkg::PH_EXPSIGN;
        end else begin
          parsed.phase = dtnp_pkg::PH_DONE;
        end
      end
      dtnp_pkg::PH_FRAC: begin
        if (is_dig) begin
          parsed.mant     = mant_nxt;
          parsed.mant_sat = sat_nxt;
          parsed.frac_cnt = frac_nxt;
        end else if (is_e) begin
          parsed.phase = dtnp_pkg::PH_EXPSIGN;
        end else begin
          parsed.phase = dtnp_pkg::PH_DONE;
        end
      end
      dtnp_pkg::PH_EXPSIGN: begin
        if (ch == dtnp_pkg::CH_MINUS) begin
          parsed.exp_neg = 1'b1;
          parsed.phase   = dtnp_pkg::PH_EXPDIG;
        end else if (ch == dtnp_pkg::CH_PLUS) begin
          parsed.phase = dtnp_pkg::PH_EXPDIG;
        end else if (is_dig) begin
          parsed.exp_mag = exp_nxt;
          parsed.phase   = dtnp_pkg::PH_EXPDIG;
        end else begin
          parsed.phase = dtnp_pkg::PH_DONE;
        end
      end
      dtnp_pkg::PH_EXPDIG: begin
        if (is_dig) begin
          parsed.exp_mag = exp_nxt;
        end else begin
          parsed.phase = dtnp_pkg::PH_DONE;
        end
      end
      default: begin
        parsed.phase = dtnp_pkg::PH_DONE;
      end
    endcase
  end

endmodule

// ===== src/decimal_text_to_number_parser.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_*      input      tdata[7:0] ch, tlast = last character of the text
// out_*     output     tdata[0] negative, [64:1] mantissa, [65] mantissa_saturated,
//                      [76:66] dec_exponent, [79:77] zero
//
// One character per cycle unless a last character waits on a stalled result register.
// Path: input register, combinational parse step (x10 add on mantissa), result register.
// rst_n is synchronous, active low; it empties both registers and clears the parse state.
// A stalled result only holds the input register when it carries a last character.
module decimal_text_to_number_parser #(
  parameter int MAX_EXPONENT = dtnp_pkg::DEF_MAX_EXPONENT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dtnp_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] ch
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dtnp_pkg::OUT_DATA_W-1:0]   out_tdata   // negative, mantissa,
                                                        // mantissa_saturated, dec_exponent
);

  logic                                 s1_valid_r;
  logic [dtnp_pkg::CH_W-1:0]            s1_ch_r;
  logic                                 s1_last_r;
  dtnp_pkg::dtnp_state_t                state_r;
  dtnp_pkg::dtnp_state_t                state_nxt;
  dtnp_pkg::dtnp_state_t                parsed;
  logic                                 out_valid_r;
  logic [dtnp_pkg::OUT_DATA_W-1:0]      out_data_r;
  logic [dtnp_pkg::OUT_DATA_W-1:0]      out_data_nxt;
  logic                                 out_free;
  logic                                 s1_adv;
  logic                                 in_acc;
  logic signed [dtnp_pkg::DEC_EXP_W-1:0] exp_signed;
  logic signed [dtnp_pkg::DEC_EXP_W-1:0] dec_exp;

  dtnp_step #(
    .MAX_EXPONENT(MAX_EXPONENT)
  ) u_step (
    .cur    (state_r),
    .ch     (s1_ch_r),
    .parsed (parsed)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign state_nxt = s1_last_r ? dtnp_pkg::STATE_RST : parsed;

  assign exp_signed = parsed.exp_neg ?
                      -$signed({2'b00, parsed.exp_mag}) : $signed({2'b00, parsed.exp_mag});
  assign dec_exp    = exp_signed - $signed({2'b00, parsed.frac_cnt});

  assign out_data_nxt = {3'b000, dec_exp, parsed.mant_sat, parsed.mant, parsed.neg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= dtnp_pkg::STATE_RST;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r   <= in_tdata[dtnp_pkg::CH_W-1:0];
      s1_last_r <= in_tlast;
    end
    if (s1_adv && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/dtnp_checker.sv =====
`timescale 1ns / 1ps
`include "decimal_text_to_number_parser_macros.svh"
module dtnp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [dtnp_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dtnp_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic signed [dtnp_pkg::DEC_EXP_W-1:0] dec_exp;
  logic                                  in_seen;

  assign dec_exp = out_tdata[76:66];
  assign in_seen = in_tvalid && in_tready && (in_tlast || !in_tlast) && (in_tdata == in_tdata);

  `DTNP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DTNP_ASSERT_NOW(a_sat_max, out_tvalid && out_tdata[65], out_tdata[64:1] == {64{1'b1}})
  `DTNP_ASSERT_NOW(a_exp_range, out_tvalid, (dec_exp >= -11'sd819) && (dec_exp <= 11'sd511))
  `DTNP_ASSERT_NOW(a_pad_zero, out_tvalid || in_seen, out_tdata[79:77] == 3'b000 || !out_tvalid)

endmodule

bind decimal_text_to_number_parser dtnp_checker u_dtnp_checker (.*);
